FILE: rtl/u8_s8_saturating_dot_product_macros.svh
// Assertion macros for the u8 x s8 saturating dot product block.
// Used by the top level; expects clk and rst in scope at the point of use.
`ifndef U8_S8_SATURATING_DOT_PRODUCT_MACROS_SVH
`define U8_S8_SATURATING_DOT_PRODUCT_MACROS_SVH

// Condition holds at every edge outside reset
`define U8DP_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent now implies consequent in the next cycle
`define U8DP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define U8DP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/u8dp_pkg.sv
// Shared constants and types for the u8 x s8 saturating dot product block.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package u8dp_pkg;

  // Chunk geometry: 16 bytes, one lane per adjacent byte pair
  localparam int CHUNK_BYTES = 16;
  localparam int LANES       = CHUNK_BYTES / 2;

  // Datapath widths
  localparam int BYTE_W  = 8;
  localparam int PROD_W  = 2 * BYTE_W + 1;   // u8 * s8
  localparam int PSUM_W  = PROD_W + 1;       // sum of two products
  localparam int PAIR_W  = 16;               // saturated pair sum
  localparam int CHUNK_W = PAIR_W + $clog2(LANES);
  localparam int SCORE_W = 27;

  // Result queue; depth must be a power of two so the pointers wrap freely
  localparam int RESQ_DEPTH = 8;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = RESQ_PTR_W + 1;

  typedef logic signed [PAIR_W-1:0]  pair_t;
  typedef logic signed [CHUNK_W-1:0] chunk_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  // Pipeline control that travels alongside the lane results
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  // Finished score leaving the merge stage
  typedef struct packed {
    logic   valid;
    score_t score;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/u8_s8_saturating_dot_product.sv
// A score goes through the lane, tree, result and queue registers to out_valid.
// Throughput: one 16-byte chunk per cycle; eight lanes work on the eight byte pairs.
// The input stalls only while 8 scores are outstanding (in flight or queued),
// which is the depth of the result queue; with out_stall low it never stalls.
// Reset (rst, synchronous, active high) clears the running sum, pipeline and queue.
`default_nettype none

`include "u8_s8_saturating_dot_product_macros.svh"

module u8_s8_saturating_dot_product (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [63:0]           vector_low,
  input  wire logic [63:0]           vector_high,
  input  wire logic [63:0]           query_low,
  input  wire logic [63:0]           query_high,
  input  wire logic                  last_chunk,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output u8dp_pkg::score_t           score
);

  logic                                   in_acc;
  logic                                   out_xfer;
  logic [u8dp_pkg::CHUNK_BYTES*u8dp_pkg::BYTE_W-1:0] vbytes;
  logic [u8dp_pkg::CHUNK_BYTES*u8dp_pkg::BYTE_W-1:0] qbytes;
  u8dp_pkg::pair_t                        pairs [u8dp_pkg::LANES];
  u8dp_pkg::ctl_t                         s1_ctl;
  u8dp_pkg::res_t                         res;

  // Result queue and credit count
  u8dp_pkg::score_t                       resq [u8dp_pkg::RESQ_DEPTH];
  logic [u8dp_pkg::RESQ_PTR_W-1:0]        wr_ptr;
  logic [u8dp_pkg::RESQ_PTR_W-1:0]        rd_ptr;
  logic [u8dp_pkg::RESQ_CNT_W-1:0]        q_count;
  logic [u8dp_pkg::RESQ_CNT_W-1:0]        q_count_next;
  logic [u8dp_pkg::RESQ_CNT_W-1:0]        used;
  logic [u8dp_pkg::RESQ_CNT_W-1:0]        used_next;
  logic                                   take;

  assign in_acc   = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign take     = in_acc && last_chunk;

  // Stall from a register only: every outstanding score holds a queue slot
  assign in_stall = (used == u8dp_pkg::RESQ_CNT_W'(u8dp_pkg::RESQ_DEPTH));

  assign vbytes = {vector_high, vector_low};
  assign qbytes = {query_high, query_low};

  // Pair lanes
  for (genvar p = 0; p < u8dp_pkg::LANES; p++) begin : g_lane
    u8dp_lane u_lane (
      .clk  (clk),
      .v0   (vbytes[(2*p)*u8dp_pkg::BYTE_W +: u8dp_pkg::BYTE_W]),
      .v1   (vbytes[(2*p+1)*u8dp_pkg::BYTE_W +: u8dp_pkg::BYTE_W]),
      .q0   ($signed(qbytes[(2*p)*u8dp_pkg::BYTE_W +: u8dp_pkg::BYTE_W])),
      .q1   ($signed(qbytes[(2*p+1)*u8dp_pkg::BYTE_W +: u8dp_pkg::BYTE_W])),
      .pair (pairs[p])
    );
  end

  // Control that follows the lane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= in_acc;
      s1_ctl.last  <= last_chunk;
    end
  end

  u8dp_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .ctl   (s1_ctl),
    .pairs (pairs),
    .res   (res)
  );

  // Result queue storage
  always_ff @(posedge clk) begin
    if (res.valid) begin
      resq[wr_ptr] <= res.score;
    end
  end

  // Occupancy and credit bookkeeping
  always_comb begin
    q_count_next = q_count;
    if (res.valid && !out_xfer) begin
      q_count_next = q_count + u8dp_pkg::RESQ_CNT_W'(1);
    end else if (!res.valid && out_xfer) begin
      q_count_next = q_count - u8dp_pkg::RESQ_CNT_W'(1);
    end
  end

  always_comb begin
    used_next = used;
    if (take && !out_xfer) begin
      used_next = used + u8dp_pkg::RESQ_CNT_W'(1);
    end else if (!take && out_xfer) begin
      used_next = used - u8dp_pkg::RESQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
      used    <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr <= wr_ptr + u8dp_pkg::RESQ_PTR_W'(1);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + u8dp_pkg::RESQ_PTR_W'(1);
      end
      q_count <= q_count_next;
      used    <= used_next;
    end
  end

  assign out_valid = (q_count != '0);
  assign score     = resq[rd_ptr];

  // Checks
  `U8DP_ASSERT_HOLDS(a_queue_within_credit, q_count <= used, "queue holds more than credited")
  `U8DP_ASSERT_SAME(a_push_has_room, res.valid, q_count < u8dp_pkg::RESQ_CNT_W'(u8dp_pkg::RESQ_DEPTH), "result pushed into full queue")
  `U8DP_ASSERT_NEXT(a_credit_taken, take && !out_xfer, used == $past(used) + u8dp_pkg::RESQ_CNT_W'(1), "credit not taken for last chunk")

endmodule

`default_nettype wire

FILE: rtl/u8dp_lane.sv
// One pair lane: v0*q0 + v1*q1, saturated to signed 16 bits, registered.
// Depends on u8dp_pkg.
`default_nettype none

module u8dp_lane (
  input  wire logic                                clk,
  input  wire logic        [u8dp_pkg::BYTE_W-1:0]  v0,
  input  wire logic        [u8dp_pkg::BYTE_W-1:0]  v1,
  input  wire logic signed [u8dp_pkg::BYTE_W-1:0]  q0,
  input  wire logic signed [u8dp_pkg::BYTE_W-1:0]  q1,
  output u8dp_pkg::pair_t                          pair
);

  logic signed [u8dp_pkg::PROD_W-1:0] prod0;
  logic signed [u8dp_pkg::PROD_W-1:0] prod1;
  logic signed [u8dp_pkg::PSUM_W-1:0] psum;
  u8dp_pkg::pair_t                    pair_next;

  // Unsigned vector byte times signed query byte
  assign prod0 = $signed({1'b0, v0}) * q0;
  assign prod1 = $signed({1'b0, v1}) * q1;
  assign psum  = u8dp_pkg::PSUM_W'(prod0) + u8dp_pkg::PSUM_W'(prod1);

  // Clamp to the signed 16-bit range
  always_comb begin
    if (psum > u8dp_pkg::PSUM_W'(32767)) begin
      pair_next = {1'b0, {(u8dp_pkg::PAIR_W-1){1'b1}}};
    end else if (psum < -u8dp_pkg::PSUM_W'(32768)) begin
      pair_next = {1'b1, {(u8dp_pkg::PAIR_W-1){1'b0}}};
    end else begin
      pair_next = psum[u8dp_pkg::PAIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pair <= pair_next;
  end

endmodule

`default_nettype wire

FILE: rtl/u8dp_merge.sv
// Merge stage: sums the lane results of a chunk, then accumulates into the
// saturating running sum and emits the score on the last chunk. Uses u8dp_pkg.
`default_nettype none

module u8dp_merge (
  input  wire logic            clk,
  input  wire logic            rst,
  input  u8dp_pkg::ctl_t       ctl,
  input  u8dp_pkg::pair_t      pairs [u8dp_pkg::LANES],
  output u8dp_pkg::res_t       res
);

  // Tree stage registers
  logic                        t_valid;
  logic                        t_last;
  u8dp_pkg::chunk_t            t_sum;
  u8dp_pkg::chunk_t            t_sum_next;

  // Accumulator
  u8dp_pkg::score_t            acc;
  logic signed [u8dp_pkg::SCORE_W:0] wide;
  u8dp_pkg::score_t            acc_sat;

  // Sum of the eight saturated pair sums
  always_comb begin
    t_sum_next = '0;
    for (int i = 0; i < u8dp_pkg::LANES; i++) begin
      t_sum_next = t_sum_next + u8dp_pkg::CHUNK_W'(pairs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      t_last  <= 1'b0;
    end else begin
      t_valid <= ctl.valid;
      t_last  <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    t_sum <= t_sum_next;
  end

  // Add the chunk sum, clamp on signed overflow of the 27-bit range
  assign wide = (u8dp_pkg::SCORE_W+1)'(acc) + (u8dp_pkg::SCORE_W+1)'(t_sum);

  always_comb begin
    if (wide[u8dp_pkg::SCORE_W] != wide[u8dp_pkg::SCORE_W-1]) begin
      acc_sat = wide[u8dp_pkg::SCORE_W] ? {1'b1, {(u8dp_pkg::SCORE_W-1){1'b0}}}
                                        : {1'b0, {(u8dp_pkg::SCORE_W-1){1'b1}}};
    end else begin
      acc_sat = wide[u8dp_pkg::SCORE_W-1:0];
    end
  end

  // Last chunk emits the score and clears the running sum
  always_ff @(posedge clk) begin
    res.score <= acc_sat;
    if (rst) begin
      acc       <= '0;
      res.valid <= 1'b0;
    end else begin
      res.valid <= t_valid && t_last;
      if (t_valid) begin
        acc <= t_last ? '0 : acc_sat;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the u8 x s8 saturating dot product block.
// Needs only the RTL: u8dp_pkg for the score type and the top level module.
// Directed chunks, a pressure burst, random vectors and a saturating long run.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCORE_MAX     = 67108863;
  localparam int SCORE_MIN     = -67108864;
  localparam int PAIR_MAX      = 32767;
  localparam int PAIR_MIN      = -32768;
  localparam int PAIRS         = 8;
  localparam int RANDOM_ITEMS  = 180;
  localparam int HOLD_CYCLES   = 100;
  localparam int BURST_VECTORS = 40;
  localparam int LONG_RUN_MIN  = 257;
  localparam int LONG_RUN_MAX  = 262;
  localparam int DRAIN_CYCLES  = 12;

  // One directed chunk; score is typed in only where known is set
  typedef struct packed {
    logic [63:0]      vl;
    logic [63:0]      vh;
    logic [63:0]      ql;
    logic [63:0]      qh;
    logic             last;
    logic             known;
    u8dp_pkg::score_t score;
  } chunk_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] vector_low = '0;
  logic [63:0] vector_high = '0;
  logic [63:0] query_low = '0;
  logic [63:0] query_high = '0;
  logic last_chunk = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  u8dp_pkg::score_t score;

  // Predictor state and the scores still owed by the block
  longint running_score = 0;
  u8dp_pkg::score_t pending_scores[$];
  u8dp_pkg::score_t want_score;
  int mismatches = 0;

  // Knobs shared between the sender and the receiver
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  logic quiet_send = 1'b0;
  logic quiet_recv = 1'b0;

  chunk_row_t directed_rows[$];

  u8_s8_saturating_dot_product dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vector_low (vector_low),
    .vector_high(vector_high),
    .query_low  (query_low),
    .query_high (query_high),
    .last_chunk (last_chunk),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .score      (score)
  );

  always #6 clk = ~clk;

  // Sum of the eight saturated pair sums of one chunk
  function automatic longint chunk_total(input logic [63:0] vl, input logic [63:0] vh,
                                         input logic [63:0] ql, input logic [63:0] qh);
    logic [127:0] v;
    logic [127:0] q;
    int v0, v1, q0, q1, pair;
    longint acc;
    v = {vh, vl};
    q = {qh, ql};
    acc = 0;
    for (int p = 0; p < PAIRS; p++) begin
      v0 = v[16*p +: 8];
      v1 = v[16*p+8 +: 8];
      q0 = $signed(q[16*p +: 8]);
      q1 = $signed(q[16*p+8 +: 8]);
      pair = v0 * q0 + v1 * q1;
      if (pair > PAIR_MAX) pair = PAIR_MAX;
      if (pair < PAIR_MIN) pair = PAIR_MIN;
      acc += pair;
    end
    return acc;
  endfunction

  function automatic longint clamp_score(input longint x);
    if (x > SCORE_MAX) return SCORE_MAX;
    if (x < SCORE_MIN) return SCORE_MIN;
    return x;
  endfunction

  // Uniform word, or one built mostly from edge byte values
  function automatic logic [63:0] rand_word(input logic edgy);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (edgy) begin
      for (int b = 0; b < 8; b++) begin
        case ($urandom_range(0, 4))
          0: w[8*b +: 8] = 8'h00;
          1: w[8*b +: 8] = 8'hFF;
          2: w[8*b +: 8] = 8'h7F;
          3: w[8*b +: 8] = 8'h80;
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  // Every byte drawn from [lo, hi]
  function automatic logic [63:0] ranged_word(input int lo, input int hi);
    logic [63:0] w;
    for (int b = 0; b < 8; b++) w[8*b +: 8] = 8'($urandom_range(lo, hi));
    return w;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pause_len(input logic quiet, input int none_pct);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < none_pct) return 0;
    if (r < none_pct + (100 - none_pct) * 3 / 4) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Offer one chunk, wait for its transfer, update the predictor, then idle
  task automatic send_chunk(input logic [63:0] vl, input logic [63:0] vh,
                            input logic [63:0] ql, input logic [63:0] qh,
                            input logic last, input logic known,
                            input u8dp_pkg::score_t known_score);
    int gap;
    vector_low  <= vl;
    vector_high <= vh;
    query_low   <= ql;
    query_high  <= qh;
    last_chunk  <= last;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    running_score = clamp_score(running_score + chunk_total(vl, vh, ql, qh));
    if (last) begin
      pending_scores.push_back(known ? known_score : u8dp_pkg::score_t'(running_score));
      running_score = 0;
    end
    gap = pause_len(quiet_send, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result check against the oldest expected score
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $error("score: expected none, actual %0d", score);
        mismatches++;
      end else begin
        want_score = pending_scores.pop_front();
        if (score !== want_score) begin
          $error("score: expected %0d, actual %0d", want_score, score);
          mismatches++;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold when asked for
  initial begin
    int k;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        k = HOLD_CYCLES;
      end else begin
        k = pause_len(quiet_recv, 70);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    int sent;
    int len;
    logic edgy_v;
    logic edgy_q;
    logic go_low;

    // Directed chunks: zero, extremes, pair saturation, byte order, multi-chunk
    directed_rows.push_back('{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b1, 27'sd0});
    directed_rows.push_back('{'1, '1, {8{8'h7F}}, {8{8'h7F}}, 1'b1, 1'b1, 27'sd262136});
    directed_rows.push_back('{'1, '1, {8{8'h80}}, {8{8'h80}}, 1'b1, 1'b1, -27'sd262144});
    directed_rows.push_back('{{8{8'h01}}, {8{8'h01}}, {8{8'h01}}, {8{8'h01}}, 1'b1, 1'b1,
                              27'sd16});
    directed_rows.push_back('{'1, '1, '1, '1, 1'b1, 1'b1, -27'sd4080});
    directed_rows.push_back('{'1, '1, {8{8'h7F}}, {8{8'h7F}}, 1'b0, 1'b0, 27'sd0});
    directed_rows.push_back('{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b1, 27'sd262136});
    directed_rows.push_back('{64'h0807060504030201, 64'h100F0E0D0C0B0A09,
                              64'h01FF01FF01FF01FF, 64'h807F02FE03FD04FC, 1'b1, 1'b0, 27'sd0});
    directed_rows.push_back('{64'h0, 64'hFF00000000000000, 64'h0, 64'h8000000000000000,
                              1'b1, 1'b0, 27'sd0});
    directed_rows.push_back('{64'h03FF, 64'h0, 64'h7F7F, 64'h0, 1'b1, 1'b0, 27'sd0});
    directed_rows.push_back('{64'h04FF, 64'h0, 64'h7F7F, 64'h0, 1'b1, 1'b0, 27'sd0});
    directed_rows.push_back('{64'h04FF, 64'h0, 64'h8080, 64'h0, 1'b1, 1'b0, 27'sd0});
    directed_rows.push_back('{64'hFFFF, 64'h0, 64'h807F, 64'h0, 1'b1, 1'b0, 27'sd0});
    directed_rows.push_back('{{8{8'h55}}, {8{8'h55}}, {8{8'hAA}}, {8{8'hAA}}, 1'b0, 1'b0,
                              27'sd0});
    directed_rows.push_back('{64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00,
                              64'h7F807F807F807F80, 64'h807F807F807F807F, 1'b0, 1'b0, 27'sd0});
    directed_rows.push_back('{64'h123456789ABCDEF0, 64'h0FEDCBA987654321,
                              64'hF0E1D2C3B4A59687, 64'h78695A4B3C2D1E0F, 1'b1, 1'b0, 27'sd0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_chunk(directed_rows[i].vl, directed_rows[i].vh, directed_rows[i].ql,
                 directed_rows[i].qh, directed_rows[i].last, directed_rows[i].known,
                 directed_rows[i].score);

    // Pressure: receiver holds off while one-chunk vectors keep coming
    quiet_send = 1'b1;
    hold_req <= 1'b1;
    for (int n = 0; n < BURST_VECTORS; n++)
      send_chunk(rand_word(1'b0), rand_word(1'b0), rand_word(1'b0), rand_word(1'b0),
                 1'b1, 1'b0, '0);
    quiet_send = 1'b0;

    // Random vectors of mostly short lengths
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(0, 99);
      if (len < 60) len = $urandom_range(1, 4);
      else if (len < 90) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 60);
      quiet_send = ($urandom_range(0, 99) < 15);
      quiet_recv = ($urandom_range(0, 99) < 15);
      edgy_v = ($urandom_range(0, 2) == 0);
      edgy_q = ($urandom_range(0, 2) == 0);
      for (int c = 0; c < len; c++)
        send_chunk(rand_word(edgy_v), rand_word(edgy_v), rand_word(edgy_q),
                   rand_word(edgy_q), c == len - 1, 1'b0, '0);
      sent += len;
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;

    // One run longer than the accumulator holds, toward a randomly chosen limit
    go_low = 1'($urandom_range(0, 1));
    len = $urandom_range(LONG_RUN_MIN, LONG_RUN_MAX);
    for (int c = 0; c < len; c++)
      send_chunk(ranged_word(192, 255), ranged_word(192, 255),
                 go_low ? ranged_word(128, 159) : ranged_word(96, 127),
                 go_low ? ranged_word(128, 159) : ranged_word(96, 127),
                 c == len - 1, 1'b0, '0);

    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/u8dp_pkg.sv
rtl/u8dp_lane.sv
rtl/u8dp_merge.sv
rtl/u8_s8_saturating_dot_product.sv
tb/testbench.sv
